[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define RCSD_ASSERT(label, clock, resetn, prop) \
  label: assert property (@(posedge clock) disable iff (!resetn) prop) \
    else $error("rcsd assertion failed");

// clocked same-cycle implication with reset disable
`define RCSD_ASSERT_IMPL(label, clock, resetn, cond, expr) \
  label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (expr)) \
    else $error("rcsd implication failed");

`endif

[hw/rtl/rcsd_pkg.sv]
// shared types and constants of the rc stick dead zone and mode switch block
`default_nettype none

package rcsd_pkg;

  localparam int CENTRE_US      = 1500;
  localparam int RANGE_LIMIT_US = 2100;

  localparam int AXIS_W      = 16;
  localparam int AXIS_MAX    = 32767;
  localparam int AXIS_NEG_MAG = 32768;
  localparam int FLAG_COUNT  = 7;

  // x = round(d * 16384 / 500) = floor((4096 * d + 62) / 125)
  localparam int DIV_PRE_SHIFT = 12;
  localparam int ROUND_BIAS    = 62;
  localparam int DIV_SHIFT     = 35;
  localparam int DIV_MULT_W    = 29;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 29'd274877907;

  localparam int GAIN_FRAC  = 14;
  localparam int ROUND_HALF = 8192;

  localparam int DZ_W   = 14;
  localparam int GAIN_W = 16;
  localparam int THR_W  = 12;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_DZ_HALF      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RESCALE_GAIN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE_THR     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GEAR_THR     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REBOOT_THR   = 3'd4;

  localparam logic [DZ_W-1:0]   DZ_HALF_RST      = 14'd819;
  localparam logic [GAIN_W-1:0] RESCALE_GAIN_RST = 16'd17246;
  localparam logic [THR_W-1:0]  THR_RST          = 12'd1750;

  typedef struct packed {
    logic [DZ_W-1:0]   dz_half;
    logic [GAIN_W-1:0] rescale_gain;
    logic [THR_W-1:0]  mode_thr;
    logic [THR_W-1:0]  gear_thr;
    logic [THR_W-1:0]  reboot_thr;
  } cfg_t;

  typedef struct packed {
    logic in_hover;
    logic hover_entered;
    logic in_command;
    logic command_entered;
    logic reboot_fire;
    logic switch_range_bad;
  } flags_t;

  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_o;
  } lane_en_t;

endpackage

`default_nettype wire

[hw/rtl/rc_stick_deadzone_and_mode_switch.sv]
// rc stick dead zone normalizer and mode switch tracker, top level
// one item per cycle unless stalled; input register, two multiply stages, output register
// stalls back up stage by stage, so empty stages keep taking items while a result waits
// reset: synchronous active low, clears pipeline valids, resets switch state and loads register defaults
`default_nettype none

module rc_stick_deadzone_and_mode_switch #(
  parameter  int STICK_CHANNELS = 4,
  parameter  int PULSE_BITS     = 12,
  localparam int IN_BITS  = (STICK_CHANNELS + 3) * PULSE_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = STICK_CHANNELS * rcsd_pkg::AXIS_W + rcsd_pkg::FLAG_COUNT,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // stick pulses by channel, then mode_pulse, gear_pulse, reboot_pulse
  input  wire logic [IN_W-1:0]                  in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // axes by channel, then in_hover, hover_entered, in_command, command_entered,
  // reboot_fire, switch_range_bad, sticks_centred
  output logic      [OUT_W-1:0]                 out_tdata,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [rcsd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [rcsd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [rcsd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int FB = STICK_CHANNELS * rcsd_pkg::AXIS_W;

  rcsd_pkg::cfg_t           cfg;
  rcsd_pkg::lane_en_t       lane_en;
  rcsd_pkg::flags_t         flags_a;
  rcsd_pkg::flags_t         flags_b_r;
  rcsd_pkg::flags_t         flags_c_r;
  rcsd_pkg::flags_t         flags_o_r;
  logic                     centred_o_r;

  logic [IN_BITS-1:0]       in_data_r;
  logic                     va_r;
  logic                     vb_r;
  logic                     vc_r;
  logic                     vo_r;
  logic                     va_nxt;
  logic                     vb_nxt;
  logic                     vc_nxt;
  logic                     vo_nxt;
  logic                     rdy_o;
  logic                     rdy_c;
  logic                     rdy_b;
  logic                     adv_a;
  logic                     adv_b;
  logic                     adv_c;
  logic                     acc;

  logic [rcsd_pkg::AXIS_W-1:0] axis [STICK_CHANNELS];
  logic [STICK_CHANNELS-1:0]   axis_zero;
  logic [OUT_W-1:0]            out_data;

  // pipeline handshake
  assign rdy_o     = !vo_r || out_tready;
  assign rdy_c     = !vc_r || rdy_o;
  assign rdy_b     = !vb_r || rdy_c;
  assign adv_c     = vc_r && rdy_o;
  assign adv_b     = vb_r && rdy_c;
  assign adv_a     = va_r && rdy_b;
  assign in_tready = !va_r || rdy_b;
  assign acc       = in_tvalid && in_tready;

  assign lane_en.en_b = adv_a;
  assign lane_en.en_c = adv_b;
  assign lane_en.en_o = adv_c;

  always_comb begin
    va_nxt = acc   ? 1'b1 : (adv_a ? 1'b0 : va_r);
    vb_nxt = adv_a ? 1'b1 : (adv_b ? 1'b0 : vb_r);
    vc_nxt = adv_b ? 1'b1 : (adv_c ? 1'b0 : vc_r);
    vo_nxt = adv_c ? 1'b1 : (out_tready ? 1'b0 : vo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      in_data_r <= in_tdata[IN_BITS-1:0];
    end
    if (adv_a) begin
      flags_b_r <= flags_a;
    end
    if (adv_b) begin
      flags_c_r <= flags_b_r;
    end
    if (adv_c) begin
      flags_o_r   <= flags_c_r;
      centred_o_r <= &axis_zero;
    end
  end

  rcsd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rcsd_switch_track #(
    .PULSE_BITS (PULSE_BITS)
  ) u_switch (
    .clk    (clk),
    .rst_n  (rst_n),
    .update (adv_a),
    .mode   (in_data_r[STICK_CHANNELS*PULSE_BITS +: PULSE_BITS]),
    .gear   (in_data_r[(STICK_CHANNELS+1)*PULSE_BITS +: PULSE_BITS]),
    .reboot (in_data_r[(STICK_CHANNELS+2)*PULSE_BITS +: PULSE_BITS]),
    .cfg    (cfg),
    .flags  (flags_a)
  );

  for (genvar i = 0; i < STICK_CHANNELS; i++) begin : g_lane
    rcsd_axis_lane #(
      .PULSE_BITS (PULSE_BITS)
    ) u_lane (
      .clk           (clk),
      .en            (lane_en),
      .pulse         (in_data_r[i*PULSE_BITS +: PULSE_BITS]),
      .dz_half       (cfg.dz_half),
      .rescale_gain  (cfg.rescale_gain),
      .axis          (axis[i]),
      .axis_zero_nxt (axis_zero[i])
    );
  end

  always_comb begin
    out_data = '0;
    for (int i = 0; i < STICK_CHANNELS; i++) begin
      out_data[i*rcsd_pkg::AXIS_W +: rcsd_pkg::AXIS_W] = axis[i];
    end
    out_data[FB]     = flags_o_r.in_hover;
    out_data[FB + 1] = flags_o_r.hover_entered;
    out_data[FB + 2] = flags_o_r.in_command;
    out_data[FB + 3] = flags_o_r.command_entered;
    out_data[FB + 4] = flags_o_r.reboot_fire;
    out_data[FB + 5] = flags_o_r.switch_range_bad;
    out_data[FB + 6] = centred_o_r;
  end

  assign out_tdata  = out_data;
  assign out_tvalid = vo_r;

endmodule

`default_nettype wire

[hw/rtl/rcsd_cfg_regs.sv]
// apb configuration registers
`default_nettype none

module rcsd_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rcsd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [rcsd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [rcsd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output rcsd_pkg::cfg_t                        cfg
);

  rcsd_pkg::cfg_t                    cfg_r;
  rcsd_pkg::cfg_t                    cfg_nxt;
  logic [rcsd_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                              wr_en;

  assign reg_idx = paddr[rcsd_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        rcsd_pkg::REG_DZ_HALF:      cfg_nxt.dz_half      = pwdata[rcsd_pkg::DZ_W-1:0];
        rcsd_pkg::REG_RESCALE_GAIN: cfg_nxt.rescale_gain = pwdata[rcsd_pkg::GAIN_W-1:0];
        rcsd_pkg::REG_MODE_THR:     cfg_nxt.mode_thr     = pwdata[rcsd_pkg::THR_W-1:0];
        rcsd_pkg::REG_GEAR_THR:     cfg_nxt.gear_thr     = pwdata[rcsd_pkg::THR_W-1:0];
        rcsd_pkg::REG_REBOOT_THR:   cfg_nxt.reboot_thr   = pwdata[rcsd_pkg::THR_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dz_half      <= rcsd_pkg::DZ_HALF_RST;
      cfg_r.rescale_gain <= rcsd_pkg::RESCALE_GAIN_RST;
      cfg_r.mode_thr     <= rcsd_pkg::THR_RST;
      cfg_r.gear_thr     <= rcsd_pkg::THR_RST;
      cfg_r.reboot_thr   <= rcsd_pkg::THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcsd_pkg::REG_DZ_HALF:      prdata = rcsd_pkg::CFG_DATA_W'(cfg_r.dz_half);
      rcsd_pkg::REG_RESCALE_GAIN: prdata = rcsd_pkg::CFG_DATA_W'(cfg_r.rescale_gain);
      rcsd_pkg::REG_MODE_THR:     prdata = rcsd_pkg::CFG_DATA_W'(cfg_r.mode_thr);
      rcsd_pkg::REG_GEAR_THR:     prdata = rcsd_pkg::CFG_DATA_W'(cfg_r.gear_thr);
      rcsd_pkg::REG_REBOOT_THR:   prdata = rcsd_pkg::CFG_DATA_W'(cfg_r.reboot_thr);
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/rcsd_axis_lane.sv]
// one stick channel: centre, scale, dead zone, gain and saturation over three stages
`default_nettype none

module rcsd_axis_lane #(
  parameter int PULSE_BITS = 12
) (
  input  wire logic                          clk,
  input  rcsd_pkg::lane_en_t                 en,
  input  wire logic [PULSE_BITS-1:0]         pulse,
  input  wire logic [rcsd_pkg::DZ_W-1:0]     dz_half,
  input  wire logic [rcsd_pkg::GAIN_W-1:0]   rescale_gain,
  output logic      [rcsd_pkg::AXIS_W-1:0]   axis,
  output logic                               axis_zero_nxt
);

  localparam int NW  = PULSE_BITS + rcsd_pkg::DIV_PRE_SHIFT;
  localparam int PW  = NW + rcsd_pkg::DIV_MULT_W;
  localparam int XW  = PW - rcsd_pkg::DIV_SHIFT;
  localparam int MPW = XW + rcsd_pkg::GAIN_W;
  localparam int SW  = MPW + 1;
  localparam int MW  = SW - rcsd_pkg::GAIN_FRAC;
  localparam logic [PULSE_BITS-1:0] CENTRE = PULSE_BITS'(rcsd_pkg::CENTRE_US);

  logic                          neg;
  logic [PULSE_BITS-1:0]         delta;
  logic [NW-1:0]                 num;
  logic [PW-1:0]                 quot_prod_nxt;
  logic [PW-1:0]                 quot_prod_r;
  logic                          neg_b_r;

  logic [XW-1:0]                 norm;
  logic [XW-1:0]                 excess;
  logic                          below_dz;
  logic [MPW-1:0]                mag_prod_nxt;
  logic [MPW-1:0]                mag_prod_r;
  logic                          zero_c_r;
  logic                          neg_c_r;

  logic [SW-1:0]                 rsum;
  logic [MW-1:0]                 mag;
  logic [rcsd_pkg::AXIS_W-1:0]   axis_nxt;
  logic [rcsd_pkg::AXIS_W-1:0]   axis_r;

  // stage a: distance from centre and constant divide by reciprocal
  assign neg           = pulse < CENTRE;
  assign delta         = neg ? CENTRE - pulse : pulse - CENTRE;
  assign num           = {delta, {rcsd_pkg::DIV_PRE_SHIFT{1'b0}}} + NW'(rcsd_pkg::ROUND_BIAS);
  assign quot_prod_nxt = PW'(num) * PW'(rcsd_pkg::DIV_MULT);

  // stage b: dead zone and gain
  assign norm         = quot_prod_r[PW-1:rcsd_pkg::DIV_SHIFT];
  assign below_dz     = norm <= XW'(dz_half);
  assign excess       = norm - XW'(dz_half);
  assign mag_prod_nxt = MPW'(excess) * MPW'(rescale_gain);

  // stage c: round, restore sign, saturate
  assign rsum = SW'(mag_prod_r) + SW'(rcsd_pkg::ROUND_HALF);
  assign mag  = rsum[SW-1:rcsd_pkg::GAIN_FRAC];

  always_comb begin
    axis_nxt = '0;
    if (!zero_c_r) begin
      if (neg_c_r) begin
        if (mag >= MW'(rcsd_pkg::AXIS_NEG_MAG)) begin
          axis_nxt = rcsd_pkg::AXIS_W'(rcsd_pkg::AXIS_NEG_MAG);
        end else begin
          axis_nxt = rcsd_pkg::AXIS_W'(0) - mag[rcsd_pkg::AXIS_W-1:0];
        end
      end else begin
        if (mag > MW'(rcsd_pkg::AXIS_MAX)) begin
          axis_nxt = rcsd_pkg::AXIS_W'(rcsd_pkg::AXIS_MAX);
        end else begin
          axis_nxt = mag[rcsd_pkg::AXIS_W-1:0];
        end
      end
    end
  end

  assign axis_zero_nxt = axis_nxt == '0;
  assign axis          = axis_r;

  always_ff @(posedge clk) begin
    if (en.en_b) begin
      quot_prod_r <= quot_prod_nxt;
      neg_b_r     <= neg;
    end
    if (en.en_c) begin
      mag_prod_r <= mag_prod_nxt;
      zero_c_r   <= below_dz;
      neg_c_r    <= neg_b_r;
    end
    if (en.en_o) begin
      axis_r <= axis_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rcsd_switch_track.sv]
// mode, gear and reboot switch tracking with entry flags
`default_nettype none

module rcsd_switch_track #(
  parameter int PULSE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   update,
  input  wire logic [PULSE_BITS-1:0]  mode,
  input  wire logic [PULSE_BITS-1:0]  gear,
  input  wire logic [PULSE_BITS-1:0]  reboot,
  input  rcsd_pkg::cfg_t              cfg,
  output rcsd_pkg::flags_t            flags
);

  localparam int CW = (PULSE_BITS > rcsd_pkg::THR_W) ? PULSE_BITS : rcsd_pkg::THR_W;

  logic [PULSE_BITS-1:0] prev_mode_r;
  logic [PULSE_BITS-1:0] prev_gear_r;
  logic [PULSE_BITS-1:0] prev_reboot_r;
  logic                  seen_r;
  logic                  hover_entry_r;
  logic                  command_r;
  logic                  command_entry_r;

  logic [CW-1:0]         pm;
  logic [CW-1:0]         pg;
  logic [CW-1:0]         pr;
  logic [CW-1:0]         cm;
  logic [CW-1:0]         cg;
  logic [CW-1:0]         cr;
  logic [CW-1:0]         mthr;
  logic [CW-1:0]         gthr;
  logic [CW-1:0]         rthr;
  logic [CW-1:0]         limit;

  logic                  hover_nxt;
  logic                  hover_entry_nxt;
  logic                  command_nxt;
  logic                  command_entry_nxt;
  logic                  fire;

  // first frame sees no crossing
  assign pm    = seen_r ? CW'(prev_mode_r)   : CW'(mode);
  assign pg    = seen_r ? CW'(prev_gear_r)   : CW'(gear);
  assign pr    = seen_r ? CW'(prev_reboot_r) : CW'(reboot);
  assign cm    = CW'(mode);
  assign cg    = CW'(gear);
  assign cr    = CW'(reboot);
  assign mthr  = CW'(cfg.mode_thr);
  assign gthr  = CW'(cfg.gear_thr);
  assign rthr  = CW'(cfg.reboot_thr);
  assign limit = CW'(rcsd_pkg::RANGE_LIMIT_US);

  always_comb begin
    hover_nxt         = cm > mthr;
    hover_entry_nxt   = hover_entry_r || (pm < mthr && hover_nxt);
    command_nxt       = command_r;
    command_entry_nxt = command_entry_r;
    if (hover_nxt) begin
      priority if (pg < gthr && cg > gthr) begin
        command_entry_nxt = 1'b1;
      end else if (cg < gthr) begin
        command_entry_nxt = 1'b0;
      end else begin
        command_entry_nxt = command_entry_r;
      end
      command_nxt = cg > gthr;
    end
    fire = !hover_nxt && !command_nxt && pr < rthr && cr > rthr;
  end

  assign flags.in_hover         = hover_nxt;
  assign flags.hover_entered    = hover_entry_nxt;
  assign flags.in_command       = command_nxt;
  assign flags.command_entered  = command_entry_nxt;
  assign flags.reboot_fire      = fire;
  assign flags.switch_range_bad = cm > limit || cg > limit || cr > limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r          <= 1'b0;
      hover_entry_r   <= 1'b0;
      command_r       <= 1'b1;
      command_entry_r <= 1'b0;
    end else if (update) begin
      seen_r          <= 1'b1;
      hover_entry_r   <= hover_entry_nxt;
      command_r       <= command_nxt;
      command_entry_r <= command_entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      prev_mode_r   <= mode;
      prev_gear_r   <= gear;
      prev_reboot_r <= reboot;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rcsd_checker.sv]
// port-level checker for the top level and its bind
`default_nettype none
`include "assert_macros.svh"

module rcsd_checker #(
  parameter  int STICK_CHANNELS = 4,
  parameter  int PULSE_BITS     = 12,
  localparam int FB       = STICK_CHANNELS * rcsd_pkg::AXIS_W,
  localparam int OUT_BITS = FB + rcsd_pkg::FLAG_COUNT,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
  localparam int IN_BITS  = (STICK_CHANNELS + 3) * PULSE_BITS
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  logic reboot_bit;
  logic hover_bit;
  logic command_bit;
  logic centred_bit;
  logic in_wide;

  assign reboot_bit  = out_tdata[FB + 4];
  assign hover_bit   = out_tdata[FB];
  assign command_bit = out_tdata[FB + 2];
  assign centred_bit = out_tdata[FB + 6];
  assign in_wide     = IN_BITS > 0;

  `RCSD_ASSERT(a_out_hold_valid, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `RCSD_ASSERT(a_out_hold_data, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  `RCSD_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_tvalid && in_wide, in_tready)
  `RCSD_ASSERT_IMPL(a_reboot_outside_modes, clk, rst_n, out_tvalid && reboot_bit, !hover_bit && !command_bit)
  `RCSD_ASSERT_IMPL(a_centred_axes_zero, clk, rst_n, out_tvalid && centred_bit, out_tdata[FB-1:0] == '0)

endmodule

bind rc_stick_deadzone_and_mode_switch rcsd_checker #(
  .STICK_CHANNELS (STICK_CHANNELS),
  .PULSE_BITS     (PULSE_BITS)
) u_rcsd_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
// testbench for the rc stick dead zone and mode switch block: streams frames, predicts results
`timescale 1ns / 1ps

module tb_top;

  localparam int IN_W        = 88;
  localparam int OUT_W       = 72;
  localparam int STALL_LIMIT = 2000;
  localparam logic [rcsd_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [rcsd_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // stick[0] is roll, then pitch, throttle, yaw
  typedef struct packed {
    logic [11:0]       reboot;
    logic [11:0]       gear;
    logic [11:0]       mode;
    logic [3:0][11:0]  stick;
  } rc_frame_t;

  typedef enum int {
    FLAG_HOVER, FLAG_HOVER_ENTERED, FLAG_COMMAND, FLAG_COMMAND_ENTERED,
    FLAG_REBOOT, FLAG_RANGE_BAD, FLAG_CENTRED
  } flag_idx_t;

  typedef struct packed {
    logic [6:0]        flag;
    logic [3:0][15:0]  axis;
  } rc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [rcsd_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [rcsd_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [rcsd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  rc_stick_deadzone_and_mode_switch dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // roll, pitch, throttle, yaw, mode, gear, reboot pulses
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // roll..yaw axes, then the seven flags
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies
  logic [rcsd_pkg::DZ_W-1:0]   dz_q         = rcsd_pkg::DZ_HALF_RST;
  logic [rcsd_pkg::GAIN_W-1:0] gain_q       = rcsd_pkg::RESCALE_GAIN_RST;
  logic [rcsd_pkg::THR_W-1:0]  mode_thr_q   = rcsd_pkg::THR_RST;
  logic [rcsd_pkg::THR_W-1:0]  gear_thr_q   = rcsd_pkg::THR_RST;
  logic [rcsd_pkg::THR_W-1:0]  reboot_thr_q = rcsd_pkg::THR_RST;

  // switch tracking state
  logic [11:0] prev_mode = '0;
  logic [11:0] prev_gear = '0;
  logic [11:0] prev_reboot = '0;
  logic        seen_q = 1'b0;
  logic        hover_q = 1'b1;
  logic        hover_ent_q = 1'b0;
  logic        cmd_q = 1'b1;
  logic        cmd_ent_q = 1'b0;

  rc_frame_t  pending_frames[$];
  rc_result_t expected_results[$];

  int errors = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int fires_seen = 0;
  int range_bad_seen = 0;
  int idle_level = 0;
  bit quiet = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int stall_cycles = 0;
  logic [11:0] gen_mode = '0;
  logic [11:0] gen_gear = '0;
  logic [11:0] gen_reboot = '0;

  string axis_name[4] = '{"roll", "pitch", "throttle", "yaw"};
  string flag_name[7] = '{"in_hover", "hover_entered", "in_command", "command_entered",
                          "reboot_fire", "switch_range_bad", "sticks_centred"};

  function automatic logic [15:0] scale_stick(logic [11:0] pulse);
    longint unsigned d;
    longint unsigned x;
    longint unsigned m;
    logic neg;
    neg = pulse < rcsd_pkg::CENTRE_US;
    d = neg ? longint'(rcsd_pkg::CENTRE_US) - pulse
            : longint'(pulse) - rcsd_pkg::CENTRE_US;
    x = (d * 8192 + 125) / 250;
    if (x <= dz_q) return 16'h0000;
    m = ((x - dz_q) * gain_q + 8192) >> 14;
    if (neg) return (m >= 32768) ? 16'h8000 : 16'(-m);
    return (m > 32767) ? 16'h7fff : 16'(m);
  endfunction

  function automatic rc_result_t predict_frame(rc_frame_t f);
    rc_result_t r;
    logic fire;
    r = '0;
    for (int i = 0; i < 4; i++) r.axis[i] = scale_stick(f.stick[i]);
    if (!seen_q) begin
      seen_q = 1'b1;
      prev_mode = f.mode;
      prev_gear = f.gear;
      prev_reboot = f.reboot;
    end
    if (prev_mode < mode_thr_q && f.mode > mode_thr_q) hover_ent_q = 1'b1;
    hover_q = f.mode > mode_thr_q;
    if (hover_q) begin
      if (prev_gear < gear_thr_q && f.gear > gear_thr_q) cmd_ent_q = 1'b1;
      else if (f.gear < gear_thr_q) cmd_ent_q = 1'b0;
      cmd_q = f.gear > gear_thr_q;
    end
    fire = !hover_q && !cmd_q && prev_reboot < reboot_thr_q && f.reboot > reboot_thr_q;
    prev_mode = f.mode;
    prev_gear = f.gear;
    prev_reboot = f.reboot;
    r.flag[FLAG_HOVER] = hover_q;
    r.flag[FLAG_HOVER_ENTERED] = hover_ent_q;
    r.flag[FLAG_COMMAND] = cmd_q;
    r.flag[FLAG_COMMAND_ENTERED] = cmd_ent_q;
    r.flag[FLAG_REBOOT] = fire;
    r.flag[FLAG_RANGE_BAD] = f.mode > rcsd_pkg::RANGE_LIMIT_US ||
                             f.gear > rcsd_pkg::RANGE_LIMIT_US ||
                             f.reboot > rcsd_pkg::RANGE_LIMIT_US;
    r.flag[FLAG_CENTRED] = (r.axis == '0);
    return r;
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_result(rc_result_t got);
    rc_result_t want;
    if (expected_results.size() == 0) begin
      note_error($sformatf("unexpected result %h", got));
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (got.flag[FLAG_REBOOT]) fires_seen++;
    if (got.flag[FLAG_RANGE_BAD]) range_bad_seen++;
    for (int i = 0; i < 4; i++)
      if (got.axis[i] !== want.axis[i])
        note_error($sformatf("result %0d %s: expected %0d, got %0d", results_checked,
                             axis_name[i], $signed(want.axis[i]), $signed(got.axis[i])));
    for (int j = 0; j < 7; j++)
      if (got.flag[j] !== want.flag[j])
        note_error($sformatf("result %0d %s: expected %b, got %b", results_checked,
                             flag_name[j], want.flag[j], got.flag[j]));
  endtask

  // input driver: presents the head of pending_frames, pops it once taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_frame(pending_frames.pop_front()));
        frames_sent++;
      end
      if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_frames.size() > 0 && !quiet && idle_level > 0 &&
                   $urandom_range(0, 15) < idle_level) begin
        in_gap = $urandom_range(0, 8);
        in_tvalid <= 1'b0;
      end else if (pending_frames.size() > 0) begin
        in_tdata <= IN_W'(pending_frames[0]);
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(rc_result_t'(out_tdata[$bits(rc_result_t)-1:0]));
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (!quiet && idle_level > 0 && $urandom_range(0, 15) < idle_level) begin
        out_stall = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [11:0] clamp_pulse(int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return 12'(v);
  endfunction

  function automatic rc_frame_t make_frame(int r, int p, int t, int y, int m, int g, int b);
    rc_frame_t f;
    f.stick[0] = 12'(r);
    f.stick[1] = 12'(p);
    f.stick[2] = 12'(t);
    f.stick[3] = 12'(y);
    f.mode = 12'(m);
    f.gear = 12'(g);
    f.reboot = 12'(b);
    return f;
  endfunction

  function automatic logic [11:0] pick_stick();
    int d;
    int side;
    side = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 5))
      0: d = $urandom_range(0, 40);
      1: d = int'((longint'(dz_q) * 500) / 16384) + int'($urandom_range(0, 3)) - 1;
      2: d = $urandom_range(0, 500);
      3: return 12'($urandom_range(0, 4095));
      4: begin
        case ($urandom_range(0, 2))
          0: return 12'd0;
          1: return 12'd4095;
          default: return 12'd1500;
        endcase
      end
      default: d = $urandom_range(0, 700);
    endcase
    return clamp_pulse(rcsd_pkg::CENTRE_US + side * d);
  endfunction

  function automatic logic [11:0] pick_switch(logic [11:0] prev, logic [11:0] thr);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = prev;
      4, 5: v = int'(thr) + int'($urandom_range(1, 300));
      6, 7: v = int'(thr) - int'($urandom_range(1, 300));
      8: v = $urandom_range(0, 1) ? int'(thr)
                                  : rcsd_pkg::RANGE_LIMIT_US + int'($urandom_range(0, 1));
      default: v = $urandom_range(0, 4095);
    endcase
    return clamp_pulse(v);
  endfunction

  task automatic queue_random_frames(int n);
    rc_frame_t f;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 4; i++) f.stick[i] = pick_stick();
      gen_mode = pick_switch(gen_mode, mode_thr_q);
      gen_gear = pick_switch(gen_gear, gear_thr_q);
      gen_reboot = pick_switch(gen_reboot, reboot_thr_q);
      f.mode = gen_mode;
      f.gear = gen_gear;
      f.reboot = gen_reboot;
      pending_frames.push_back(f);
    end
  endtask

  task automatic wait_drained();
    while (pending_frames.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [rcsd_pkg::REG_IDX_W-1:0] idx,
                           logic [rcsd_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    reg_writes++;
    case (idx)
      rcsd_pkg::REG_DZ_HALF:      dz_q = value[rcsd_pkg::DZ_W-1:0];
      rcsd_pkg::REG_RESCALE_GAIN: gain_q = value[rcsd_pkg::GAIN_W-1:0];
      rcsd_pkg::REG_MODE_THR:     mode_thr_q = value[rcsd_pkg::THR_W-1:0];
      rcsd_pkg::REG_GEAR_THR:     gear_thr_q = value[rcsd_pkg::THR_W-1:0];
      rcsd_pkg::REG_REBOOT_THR:   reboot_thr_q = value[rcsd_pkg::THR_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits carry junk, only the register width should count
  task automatic set_config(logic [rcsd_pkg::DZ_W-1:0] dz, logic [rcsd_pkg::GAIN_W-1:0] gain,
                            logic [rcsd_pkg::THR_W-1:0] mthr, logic [rcsd_pkg::THR_W-1:0] gthr,
                            logic [rcsd_pkg::THR_W-1:0] rthr);
    write_reg(rcsd_pkg::REG_DZ_HALF, {18'($urandom()), dz});
    write_reg(rcsd_pkg::REG_RESCALE_GAIN, {16'($urandom()), gain});
    write_reg(rcsd_pkg::REG_MODE_THR, {20'($urandom()), mthr});
    write_reg(rcsd_pkg::REG_GEAR_THR, {20'($urandom()), gthr});
    write_reg(rcsd_pkg::REG_REBOOT_THR, {20'($urandom()), rthr});
  endtask

  task automatic set_random_config();
    set_config(14'($urandom_range(0, 4000)), 16'($urandom_range(16384, 65535)),
               12'($urandom_range(1000, 2200)), 12'($urandom_range(1000, 2200)),
               12'($urandom_range(1000, 2200)));
  endtask

  task automatic run_random(int level, int n);
    idle_level = level;
    queue_random_frames(n);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first frame, stick extremes, dead zone edges, switch crossings
    idle_level = 3;
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 2000, 2000, 2000));
    pending_frames.push_back(make_frame(0, 4095, 1000, 2000, 2000, 2000, 2000));
    pending_frames.push_back(make_frame(1525, 1475, 1526, 1474, 1000, 2000, 1000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 1750, 2000, 2000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 2000, 1000, 1000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 1000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 2000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 2000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 1750));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 1000, 1000, 1800));
    pending_frames.push_back(make_frame(1600, 1400, 1500, 1500, 1000, 1000, 1000));
    pending_frames.push_back(make_frame(1500, 1500, 1700, 1300, 2000, 1000, 1000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 2000, 2000, 1000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 2000, 1750, 1000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 2000, 1000, 1000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 2101, 1000, 1000));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 2100, 2100, 2100));
    pending_frames.push_back(make_frame(1500, 1500, 1500, 1500, 1000, 4095, 4095));
    pending_frames.push_back(make_frame(4095, 4095, 4095, 4095, 4095, 4095, 4095));
    pending_frames.push_back(make_frame(0, 0, 0, 0, 0, 0, 0));
    pending_frames.push_back(make_frame(2595, 405, 1999, 1001, 1000, 1000, 2200));
    pending_frames.push_back(make_frame(2730, 2730, 1365, 1365, 1000, 1000, 1000));
    wait_drained();

    set_random_config();
    run_random(4, 300);

    // no dead zone, unit gain, zero thresholds
    set_config(14'd0, 16'd16384, 12'd0, 12'd0, 12'd0);
    run_random(0, 200);

    // widest dead zone, largest gain, top thresholds
    set_config(14'd16383, 16'd65535, 12'd4095, 12'd4095, 12'd4095);
    run_random(6, 200);

    // gain below unity, and writes to unused addresses
    set_config(14'($urandom_range(0, 2000)), 16'($urandom_range(0, 16383)),
               12'd1500, 12'd1500, 12'd1500);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    run_random(8, 250);

    set_random_config();
    run_random(2, 300);

    set_config(rcsd_pkg::DZ_HALF_RST, rcsd_pkg::RESCALE_GAIN_RST, 12'd1000, 12'd2000,
               rcsd_pkg::THR_RST);
    run_random(5, 300);

    set_random_config();
    quiet = 1'b1;
    run_random(0, 200);

    if (expected_results.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_results.size()));
    $display("%0d frames sent, %0d results checked over %0d register writes",
             frames_sent, results_checked, reg_writes);
    $display("reboot pulses seen: %0d, frames with bad switch range: %0d",
             fires_seen, range_bad_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/rcsd_pkg.sv
hw/rtl/rcsd_cfg_regs.sv
hw/rtl/rcsd_axis_lane.sv
hw/rtl/rcsd_switch_track.sv
hw/rtl/rc_stick_deadzone_and_mode_switch.sv
hw/rtl/rcsd_checker.sv
tb/tb_top.sv
